// ----- hdl/ypdd_pkg.sv -----
`timescale 1ns / 1ps
package ypdd_pkg;

    localparam int DEF_FRAC_BITS     = 4;
    localparam int YAW_W             = 16;
    localparam int ERR_W             = YAW_W + 1;
    localparam int GAIN_W            = 16;
    localparam int KP_W              = GAIN_W + 1;
    localparam int BASE_W            = 8;
    localparam int DZ_W              = 15;
    localparam int SPEED_W           = 8;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 16;
    localparam int MID_DEPTH         = 4;
    localparam int OUT_DEPTH         = 8;
    localparam int INT_LIMIT_WHOLE   = 150;
    localparam int KP_DOUBLE_WHOLE   = 40;
    localparam int SPEED_MAX         = 255;

    typedef struct packed {
        logic                    dz;
        logic signed [ERR_W-1:0] err;
    } t_mid_item;

    typedef struct packed {
        logic               left_reverse;
        logic [SPEED_W-1:0] left_speed;
        logic               right_reverse;
        logic [SPEED_W-1:0] right_speed;
    } t_result;

    typedef struct packed {
        logic [KP_W-1:0]   kp;
        logic [GAIN_W-1:0] ki;
        logic [BASE_W-1:0] base;
        logic              int_clr;
    } t_back_cfg;

endpackage

// ----- hdl/yaw_pi_differential_drive.sv -----
`timescale 1ns / 1ps
// A transfer on push passes the middle queue and stages s1 to s4 to the result side (empty low).
// Throughput: one item per cycle while the output queue has room; r_int updates once per item.
// Disabled ticks are accepted and give no result.
// Reset: synchronous, active low; clears queues, pipeline valids and the integral,
// and loads register defaults.
module yaw_pi_differential_drive
    import ypdd_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic signed [YAW_W-1:0] i_yaw_rate,
    output logic                    empty,
    input  logic                    pop,
    output logic                    o_left_reverse,
    output logic [SPEED_W-1:0]      o_left_speed,
    output logic                    o_right_reverse,
    output logic [SPEED_W-1:0]      o_right_speed,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_YAW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE  = 3'd5;
    localparam logic signed [ERR_W-1:0] KP_TH = ERR_W'(KP_DOUBLE_WHOLE) <<< FRAC_BITS;

    logic                    r_enable;
    logic signed [YAW_W-1:0] r_target_yaw;
    logic [BASE_W-1:0]       r_base_speed;
    logic [GAIN_W-1:0]       r_kp_gain;
    logic [GAIN_W-1:0]       r_ki_gain;
    logic [DZ_W-1:0]         r_dead_zone;

    logic                    q_wr;
    t_mid_item               q_wdata;
    t_mid_item               q_rdata;
    logic                    q_empty;
    logic                    q_pop;
    logic [$clog2(MID_DEPTH+1)-1:0] q_count;
    logic                    kp_dbl;
    t_back_cfg               back_cfg;
    t_result                 result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_target_yaw <= '0;
            r_base_speed <= BASE_W'(150);
            r_kp_gain    <= GAIN_W'(256);
            r_ki_gain    <= '0;
            r_dead_zone  <= DZ_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENABLE:     r_enable     <= i_cfg_data[0];
                CFG_TARGET_YAW: r_target_yaw <= $signed(i_cfg_data[YAW_W-1:0]);
                CFG_BASE_SPEED: r_base_speed <= i_cfg_data[BASE_W-1:0];
                CFG_KP_GAIN:    r_kp_gain    <= i_cfg_data[GAIN_W-1:0];
                CFG_KI_GAIN:    r_ki_gain    <= i_cfg_data[GAIN_W-1:0];
                CFG_DEAD_ZONE:  r_dead_zone  <= i_cfg_data[DZ_W-1:0];
                default:        r_enable     <= r_enable;
            endcase
        end
    end

    assign kp_dbl = (ERR_W'(r_target_yaw) >= KP_TH) || (ERR_W'(r_target_yaw) <= -KP_TH);

    assign back_cfg.kp      = kp_dbl ? {r_kp_gain, 1'b0} : {1'b0, r_kp_gain};
    assign back_cfg.ki      = r_ki_gain;
    assign back_cfg.base    = r_base_speed;
    assign back_cfg.int_clr = i_cfg_we && (i_cfg_idx == CFG_ENABLE);

    ypdd_front u_front (
        .i_push       (push),
        .i_q_full     (full),
        .i_enable     (r_enable),
        .i_yaw_rate   (i_yaw_rate),
        .i_target_yaw (r_target_yaw),
        .i_dead_zone  (r_dead_zone),
        .o_q_wr       (q_wr),
        .o_q_item     (q_wdata)
    );

    ypdd_fifo #(
        .W     ($bits(t_mid_item)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_wr),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_full  (full),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    ypdd_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (back_cfg),
        .i_q_empty (q_empty),
        .i_q_item  (q_rdata),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (result)
    );

    assign o_left_reverse  = result.left_reverse;
    assign o_left_speed    = result.left_speed;
    assign o_right_reverse = result.right_reverse;
    assign o_right_speed   = result.right_speed;

    logic unused_count;
    assign unused_count = ^q_count;

endmodule

// ----- hdl/ypdd_fifo.sv -----
`timescale 1ns / 1ps
module ypdd_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [W-1:0]                 i_wdata,
    input  logic                         i_pop,
    output logic [W-1:0]                 o_rdata,
    output logic                         o_full,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          wr_en;
    logic          rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_rdata = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

// ----- hdl/ypdd_front.sv -----
`timescale 1ns / 1ps
module ypdd_front
    import ypdd_pkg::*;
(
    input  logic                    i_push,
    input  logic                    i_q_full,
    input  logic                    i_enable,
    input  logic signed [YAW_W-1:0] i_yaw_rate,
    input  logic signed [YAW_W-1:0] i_target_yaw,
    input  logic [DZ_W-1:0]         i_dead_zone,
    output logic                    o_q_wr,
    output t_mid_item               o_q_item
);
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] dz_s;
    logic                    in_dz;

    assign err   = ERR_W'(i_target_yaw) - ERR_W'(i_yaw_rate);
    assign dz_s  = $signed({{(ERR_W-DZ_W){1'b0}}, i_dead_zone});
    assign in_dz = (err > -dz_s) && (err < dz_s);

    // drop ticks while disabled
    assign o_q_wr       = i_push && !i_q_full && i_enable;
    assign o_q_item.dz  = in_dz;
    assign o_q_item.err = in_dz ? '0 : err;

endmodule

// ----- hdl/ypdd_back.sv -----
`timescale 1ns / 1ps
module ypdd_back
    import ypdd_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_back_cfg i_cfg,
    input  logic      i_q_empty,
    input  t_mid_item i_q_item,
    output logic      o_q_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_result   o_result
);
    localparam int PROD_FRAC = FRAC_BITS + 8;
    localparam int INT_W     = PROD_FRAC + 9;
    localparam int PI_W      = ERR_W + GAIN_W + 1;
    localparam int PP_W      = ERR_W + KP_W + 1;
    localparam int SUM_W     = 36;
    localparam int OCW       = $clog2(OUT_DEPTH + 1);
    localparam logic signed [SUM_W-1:0] INT_LIM = SUM_W'(INT_LIMIT_WHOLE) <<< PROD_FRAC;
    localparam int DRV_W     = 18;

    logic                     r_s1_v;
    t_mid_item                r_s1_item;
    logic                     r_s2_v;
    logic                     r_s2_dz;
    logic signed [PI_W-1:0]   r_s2_pi;
    logic signed [PP_W-1:0]   r_s2_pp;
    logic                     r_s3_v;
    logic signed [PP_W-1:0]   r_s3_pp;
    logic signed [INT_W-1:0]  r_s3_int;
    logic                     r_s4_v;
    logic signed [15:0]       r_s4_corr;
    logic signed [INT_W-1:0]  r_int;

    logic signed [PI_W-1:0]   n_pi;
    logic signed [PP_W-1:0]   n_pp;
    logic signed [SUM_W-1:0]  int_sum;
    logic signed [INT_W-1:0]  n_int;
    logic signed [SUM_W-1:0]  acc;
    logic [SUM_W-1:0]         acc_mag;
    logic [SUM_W-1:0]         acc_q;
    logic signed [15:0]       n_corr;
    logic signed [DRV_W-1:0]  base_s;
    logic [8:0]               drv_l;
    logic [8:0]               drv_r;
    t_result                  res;
    logic [OCW-1:0]           out_count;
    logic [OCW:0]             occ;
    logic                     out_full;

    function automatic logic [8:0] drive(input logic signed [DRV_W-1:0] s);
        logic [DRV_W-1:0] m;
        m = s[DRV_W-1] ? DRV_W'(-s) : DRV_W'(s);
        drive[8]   = s[DRV_W-1];
        drive[7:0] = (m > DRV_W'(SPEED_MAX)) ? 8'(SPEED_MAX) : m[7:0];
    endfunction

    // issue only with room reserved for everything in flight
    assign occ = (OCW+1)'(out_count) + (OCW+1)'(r_s1_v) + (OCW+1)'(r_s2_v)
               + (OCW+1)'(r_s3_v) + (OCW+1)'(r_s4_v);
    assign o_q_pop = !i_q_empty && (occ < (OCW+1)'(OUT_DEPTH));

    assign n_pi = r_s1_item.err * $signed({1'b0, i_cfg.ki});
    assign n_pp = r_s1_item.err * $signed({1'b0, i_cfg.kp});

    always_comb begin
        int_sum = SUM_W'(r_int) + SUM_W'(r_s2_pi);
        if (r_s2_dz) begin
            n_int = '0;
        end else if (int_sum > INT_LIM) begin
            n_int = INT_W'(INT_LIM);
        end else if (int_sum < -INT_LIM) begin
            n_int = INT_W'(-INT_LIM);
        end else begin
            n_int = int_sum[INT_W-1:0];
        end
    end

    always_comb begin
        acc     = SUM_W'(r_s3_pp) + SUM_W'(r_s3_int);
        acc_mag = acc[SUM_W-1] ? SUM_W'(-acc) : SUM_W'(acc);
        acc_q   = acc_mag >> PROD_FRAC;
        if (acc[SUM_W-1]) begin
            n_corr = (acc_q >= SUM_W'(32768)) ? 16'sh8000 : 16'(-acc_q);
        end else begin
            n_corr = (acc_q >= SUM_W'(32767)) ? 16'sh7FFF : 16'(acc_q);
        end
    end

    assign base_s = $signed({{(DRV_W-BASE_W){1'b0}}, i_cfg.base});
    assign drv_l  = drive(base_s + DRV_W'(r_s4_corr));
    assign drv_r  = drive(base_s - DRV_W'(r_s4_corr));

    assign res.left_reverse  = drv_l[8];
    assign res.left_speed    = drv_l[7:0];
    assign res.right_reverse = drv_r[8];
    assign res.right_speed   = drv_r[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_int  <= '0;
        end else begin
            r_s1_v <= o_q_pop;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            if (i_cfg.int_clr) begin
                r_int <= '0;
            end else if (r_s2_v) begin
                r_int <= n_int;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_item <= i_q_item;
        r_s2_dz   <= r_s1_item.dz;
        r_s2_pi   <= n_pi;
        r_s2_pp   <= n_pp;
        r_s3_pp   <= r_s2_pp;
        r_s3_int  <= n_int;
        r_s4_corr <= n_corr;
    end

    ypdd_fifo #(
        .W     ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s4_v),
        .i_wdata (res),
        .i_pop   (i_pop),
        .o_rdata (o_result),
        .o_full  (out_full),
        .o_empty (o_empty),
        .o_count (out_count)
    );

    logic unused_full;
    assign unused_full = out_full;

endmodule

// ----- tb/ypdd_tb_pkg.sv -----
`timescale 1ns / 1ps
package ypdd_tb_pkg;
    import ypdd_pkg::*;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE,
        REG_TARGET_YAW,
        REG_BASE_SPEED,
        REG_KP_GAIN,
        REG_KI_GAIN,
        REG_DEAD_ZONE,
        REG_SPARE_A,
        REG_SPARE_B
    } t_cfg_reg;

    localparam int     PROD_FRAC   = DEF_FRAC_BITS + 8;
    localparam longint INTEG_CAP   = longint'(INT_LIMIT_WHOLE) <<< PROD_FRAC;
    localparam longint KP_BOOST_AT = longint'(KP_DOUBLE_WHOLE) <<< DEF_FRAC_BITS;
    localparam longint CORR_MAX    = 32767;
    localparam longint CORR_MIN    = -32768;
    localparam int     REPORT_MAX  = 10;

    class yaw_drive_scoreboard;
        bit                      enable;
        logic signed [YAW_W-1:0] target;
        logic [BASE_W-1:0]       base;
        logic [GAIN_W-1:0]       kp;
        logic [GAIN_W-1:0]       ki;
        logic [DZ_W-1:0]         dz;
        longint                  integ;
        t_result                 motor_q[$];
        int                      fails;

        function new();
            enable = 1'b0;
            target = '0;
            base   = 8'd150;
            kp     = 16'd256;
            ki     = '0;
            dz     = 15'd16;
            integ  = 0;
            fails  = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_ENABLE: begin
                    enable = d[0];
                    integ  = 0;
                end
                REG_TARGET_YAW: target = d;
                REG_BASE_SPEED: base = d[BASE_W-1:0];
                REG_KP_GAIN:    kp = d;
                REG_KI_GAIN:    ki = d;
                REG_DEAD_ZONE:  dz = d[DZ_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [SPEED_W:0] motor(longint s);
            longint m;
            m = (s < 0) ? -s : s;
            if (m > SPEED_MAX) m = SPEED_MAX;
            return {s < 0, m[SPEED_W-1:0]};
        endfunction

        function void note_input(logic signed [YAW_W-1:0] yaw);
            longint  err;
            longint  gain;
            longint  acc;
            longint  corr;
            t_result r;
            if (!enable) return;
            err = longint'(target) - longint'(yaw);
            if (err > -longint'(dz) && err < longint'(dz)) begin
                err   = 0;
                integ = 0;
            end
            integ += err * longint'(ki);
            if (integ > INTEG_CAP) integ = INTEG_CAP;
            if (integ < -INTEG_CAP) integ = -INTEG_CAP;
            gain = longint'(kp);
            if (longint'(target) >= KP_BOOST_AT || longint'(target) <= -KP_BOOST_AT) begin
                gain *= 2;
            end
            acc  = gain * err + integ;
            corr = (acc < 0) ? -((-acc) >>> PROD_FRAC) : (acc >>> PROD_FRAC);
            if (corr > CORR_MAX) corr = CORR_MAX;
            if (corr < CORR_MIN) corr = CORR_MIN;
            {r.left_reverse, r.left_speed}   = motor(longint'(base) + corr);
            {r.right_reverse, r.right_speed} = motor(longint'(base) - corr);
            motor_q.push_back(r);
        endfunction

        function void flag(string msg);
            fails++;
            if (fails <= REPORT_MAX) $display("%s", msg);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (motor_q.size() == 0) begin
                flag($sformatf("unexpected result: L %0d/%0d R %0d/%0d",
                               got.left_reverse, got.left_speed,
                               got.right_reverse, got.right_speed));
                return;
            end
            want = motor_q.pop_front();
            if (got.left_reverse !== want.left_reverse || got.left_speed !== want.left_speed ||
                got.right_reverse !== want.right_reverse ||
                got.right_speed !== want.right_speed) begin
                flag($sformatf("mismatch: expected L %0d/%0d R %0d/%0d, got L %0d/%0d R %0d/%0d",
                               want.left_reverse, want.left_speed,
                               want.right_reverse, want.right_speed,
                               got.left_reverse, got.left_speed,
                               got.right_reverse, got.right_speed));
            end
        endfunction

        function int pending();
            return motor_q.size();
        endfunction
    endclass

endpackage

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import ypdd_pkg::*;
    import ypdd_tb_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int BOOST_RAW     = KP_DOUBLE_WHOLE << DEF_FRAC_BITS;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    push = 1'b0;
    logic                    full;
    logic signed [YAW_W-1:0] i_yaw_rate = '0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic                    o_left_reverse;
    logic [SPEED_W-1:0]      o_left_speed;
    logic                    o_right_reverse;
    logic [SPEED_W-1:0]      o_right_speed;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    int push_max = 6;
    int pop_max = 6;
    int live_items = 0;
    yaw_drive_scoreboard sb;

    always #2 i_clk = ~i_clk;

    yaw_pi_differential_drive dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_yaw_rate      (i_yaw_rate),
        .empty           (empty),
        .pop             (pop),
        .o_left_reverse  (o_left_reverse),
        .o_left_speed    (o_left_speed),
        .o_right_reverse (o_right_reverse),
        .o_right_speed   (o_right_speed),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin : watchdog
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin : result_sink
        int      stall;
        t_result got;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = $urandom_range(0, pop_max);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            got.left_reverse  = o_left_reverse;
            got.left_speed    = o_left_speed;
            got.right_reverse = o_right_reverse;
            got.right_speed   = o_right_speed;
            sb.check_result(got);
        end
    end

    task automatic send_yaw(logic signed [YAW_W-1:0] v);
        int gap;
        gap = $urandom_range(0, push_max);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push       <= 1'b1;
        i_yaw_rate <= v;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (sb.enable) live_items++;
        sb.note_input(v);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        sb.write_reg(idx, d);
    endtask

    // drain every pending transfer, then let the pipeline go quiet
    task automatic settle();
        push     <= 1'b0;
        i_cfg_we <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [YAW_W-1:0] near_target(int spread);
        int y;
        y = int'(sb.target) + int'($urandom_range(0, 2 * spread)) - spread;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        return y[YAW_W-1:0];
    endfunction

    task automatic random_config();
        logic [CFG_DATA_W-1:0] d;
        if ($urandom_range(0, 1) == 1) begin
            d    = CFG_DATA_W'($urandom);
            d[0] = ($urandom_range(0, 6) != 0);
            write_reg(REG_ENABLE, d);
        end
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 3))
                0: d = CFG_DATA_W'($urandom);
                1: d = CFG_DATA_W'(($urandom_range(0, 1) == 1 ? BOOST_RAW : -BOOST_RAW)
                                   + int'($urandom_range(0, 6)) - 3);
                default: d = CFG_DATA_W'(int'($urandom_range(0, 4000)) - 2000);
            endcase
            write_reg(REG_TARGET_YAW, d);
        end
        if ($urandom_range(0, 3) != 0) write_reg(REG_BASE_SPEED, CFG_DATA_W'($urandom));
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 2))
                0: d = CFG_DATA_W'($urandom_range(0, 512));
                1: d = CFG_DATA_W'($urandom_range(0, 4096));
                default: d = CFG_DATA_W'($urandom);
            endcase
            write_reg(REG_KP_GAIN, d);
        end
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 3))
                0, 1: d = CFG_DATA_W'($urandom_range(0, 64));
                2: d = CFG_DATA_W'($urandom_range(0, 1024));
                default: d = CFG_DATA_W'($urandom);
            endcase
            write_reg(REG_KI_GAIN, d);
        end
        if ($urandom_range(0, 3) != 0) begin
            d = ($urandom_range(0, 2) != 0) ? CFG_DATA_W'($urandom_range(0, 64))
                                            : CFG_DATA_W'($urandom);
            d[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
            write_reg(REG_DEAD_ZONE, d);
        end
        if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
        if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
    endtask

    initial begin : stimulus
        int n;
        int pick;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disabled after reset: transfers give nothing
        send_yaw(16'sd100);
        send_yaw(-16'sd100);
        settle();
        write_reg(REG_ENABLE, 16'h0001);
        write_reg(REG_KI_GAIN, 16'd256);
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'h1234);
        settle();
        // dead zone edges around a zero target, then full-scale errors
        send_yaw(16'sd0);
        send_yaw(16'sd15);
        send_yaw(-16'sd15);
        send_yaw(16'sd16);
        send_yaw(-16'sd16);
        send_yaw(16'sh7FFF);
        send_yaw(16'sh8000);
        send_yaw(16'sd0);
        settle();

        // boosted gain at the threshold, max gains, masked zero dead zone, max base
        write_reg(REG_TARGET_YAW, CFG_DATA_W'(BOOST_RAW));
        write_reg(REG_KP_GAIN, 16'hFFFF);
        write_reg(REG_KI_GAIN, 16'hFFFF);
        write_reg(REG_DEAD_ZONE, 16'h8000);
        write_reg(REG_BASE_SPEED, 16'hFFFF);
        settle();
        send_yaw(16'(BOOST_RAW));
        send_yaw(16'sh8000);
        send_yaw(16'sh7FFF);
        send_yaw(16'sh8000);
        settle();

        write_reg(REG_TARGET_YAW, CFG_DATA_W'(-BOOST_RAW));
        write_reg(REG_BASE_SPEED, 16'hAB00);
        write_reg(REG_KP_GAIN, 16'd1);
        write_reg(REG_KI_GAIN, 16'd1);
        write_reg(REG_DEAD_ZONE, 16'h7FFF);
        settle();
        send_yaw(16'(-BOOST_RAW));
        send_yaw(16'sh7FFF);
        send_yaw(16'sh8000);
        settle();

        // just below the boost threshold on both sides
        write_reg(REG_TARGET_YAW, CFG_DATA_W'(BOOST_RAW - 1));
        write_reg(REG_KP_GAIN, 16'd256);
        write_reg(REG_KI_GAIN, 16'd0);
        write_reg(REG_DEAD_ZONE, 16'd0);
        write_reg(REG_BASE_SPEED, 16'd128);
        settle();
        send_yaw(16'sd0);
        send_yaw(16'(2 * BOOST_RAW - 1));
        settle();
        write_reg(REG_TARGET_YAW, CFG_DATA_W'(1 - BOOST_RAW));
        settle();
        send_yaw(16'sd0);
        settle();
        write_reg(REG_TARGET_YAW, 16'h8000);
        settle();
        send_yaw(16'sh7FFF);
        send_yaw(16'sh8000);
        settle();
        write_reg(REG_TARGET_YAW, 16'h7FFF);
        settle();
        send_yaw(16'sh8000);
        settle();

        // enable masked to bit 0: disabled
        write_reg(REG_ENABLE, 16'hFFFE);
        settle();
        send_yaw(16'sd5);
        settle();
        // accumulate, then clear the integral by rewriting enable
        write_reg(REG_ENABLE, 16'h0001);
        write_reg(REG_TARGET_YAW, 16'd0);
        write_reg(REG_KI_GAIN, 16'd4096);
        settle();
        send_yaw(16'sd100);
        send_yaw(16'sd100);
        settle();
        write_reg(REG_ENABLE, 16'h0001);
        settle();
        send_yaw(16'sd100);
        settle();

        live_items = 0;
        while (live_items < RANDOM_ITEMS) begin
            random_config();
            push_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
            pop_max  = ($urandom_range(0, 2) == 0) ? 0 : 6;
            settle();
            n = $urandom_range(20, 80);
            repeat (n) begin
                pick = $urandom_range(0, 19);
                if (pick < 12) send_yaw(near_target(2 * int'(sb.dz) + 64));
                else if (pick < 17) send_yaw(near_target(400));
                else send_yaw(YAW_W'($urandom));
            end
            settle();
        end

        sb.fails += sb.pending();
        if (sb.fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- yaw_pi_differential_drive.f -----
hdl/ypdd_pkg.sv
hdl/ypdd_fifo.sv
hdl/ypdd_front.sv
hdl/ypdd_back.sv
hdl/yaw_pi_differential_drive.sv
tb/ypdd_tb_pkg.sv
tb/testbench.sv
